@@ src/tch_pkg.sv @@
// ----------------------------------------------------------------------------
// tch_pkg: shared types, constants and helpers for the text console
// Screen geometry, character codes, the command classes passed from the
// front end to the execute unit, and the address arithmetic the execute unit uses.
// ----------------------------------------------------------------------------
package tch_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Index widths.
    localparam int CIDX_W = $clog2(COLUMNS);
    localparam int RIDX_W = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CT_W   = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int RT_W   = $clog2(ROWS + 1);

    // Number of tab stops that can follow any column.
    localparam int TAB_STOPS = COLUMNS / TAB_WIDTH + 1;

    // Decoupling queue depth.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int READ_ROW_W = 5;
    localparam int READ_COL_W = 7;
    localparam int CURSOR_W   = 11;
    localparam int CELL_W     = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'h80;

    // White-on-black space.
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Operation classes as seen by the execute unit.
    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_BS    = 3'd2,
        OP_TAB   = 3'd3,
        OP_CR    = 3'd4,
        OP_LF    = 3'd5,
        OP_PRINT = 3'd6
    } t_op;

    // One classified item on its way to the execute unit.
    typedef struct packed {
        t_op                    op;
        logic [CHAR_W-1:0]      char_code;
        logic [COLOR_W-1:0]     bg_color;
        logic [COLOR_W-1:0]     fg_color;
        logic [READ_ROW_W-1:0]  read_row;
        logic [READ_COL_W-1:0]  read_col;
        logic                   in_range;
    } t_entry;

    // Map a logical row to its physical row in the circular row store.
    function automatic logic [RIDX_W-1:0] row_map(input logic [RIDX_W-1:0] row,
                                                  input logic [RIDX_W-1:0] top);
        logic [RIDX_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (RIDX_W + 1)'(ROWS)) begin
            sum = sum - (RIDX_W + 1)'(ROWS);
        end
        return sum[RIDX_W-1:0];
    endfunction

    // Linear store address of a physical row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [RIDX_W-1:0] row,
                                                    input logic [CIDX_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    // Next tab stop strictly after the given column.
    function automatic logic [CT_W-1:0] tab_next(input logic [CIDX_W-1:0] col);
        logic [CT_W-1:0] res;
        res = '0;
        for (int k = TAB_STOPS; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(col)) begin
                res = CT_W'(k * TAB_WIDTH);
            end
        end
        return res;
    endfunction

endpackage

@@ src/tch_front.sv @@
// ----------------------------------------------------------------------------
// tch_front: input stage of the text console
// Accepts items, classifies the command and character into one operation,
// checks the read coordinates and hands the entry to the decoupling queue.
// ----------------------------------------------------------------------------
module tch_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tch_pkg::CMD_W-1:0]         i_cmd,
    input  logic [tch_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tch_pkg::COLOR_W-1:0]       i_bg_color,
    input  logic [tch_pkg::COLOR_W-1:0]       i_fg_color,
    input  logic [tch_pkg::READ_ROW_W-1:0]    i_read_row,
    input  logic [tch_pkg::READ_COL_W-1:0]    i_read_col,
    output logic                              o_q_push,
    output tch_pkg::t_entry                   o_q_entry,
    input  logic                              i_q_full
);

    logic            r_vld;
    logic            n_vld;
    tch_pkg::t_entry r_ent;
    tch_pkg::t_entry n_ent;
    tch_pkg::t_op    op;
    logic            accept;

    // The stage holds while the queue is full.
    assign full   = r_vld & i_q_full;
    assign accept = push & ~full;

    // Classify the command and the character byte.
    always_comb begin
        op = tch_pkg::OP_READ;
        case (i_cmd)
            tch_pkg::CMD_PUT: begin
                if (i_char_code >= tch_pkg::CHAR_HIGH) begin
                    op = tch_pkg::OP_READ;
                end else if (i_char_code == tch_pkg::CHAR_BS) begin
                    op = tch_pkg::OP_BS;
                end else if (i_char_code == tch_pkg::CHAR_TAB) begin
                    op = tch_pkg::OP_TAB;
                end else if (i_char_code == tch_pkg::CHAR_CR) begin
                    op = tch_pkg::OP_CR;
                end else if (i_char_code == tch_pkg::CHAR_LF) begin
                    op = tch_pkg::OP_LF;
                end else if (i_char_code >= tch_pkg::CHAR_SPACE) begin
                    op = tch_pkg::OP_PRINT;
                end else begin
                    op = tch_pkg::OP_READ;
                end
            end
            tch_pkg::CMD_CLEAR: begin
                op = tch_pkg::OP_CLEAR;
            end
            tch_pkg::CMD_READ: begin
                op = tch_pkg::OP_READ;
            end
            default: begin
                op = tch_pkg::OP_READ;
            end
        endcase
    end

    // Build the entry.
    always_comb begin
        n_ent.op         = op;
        n_ent.char_code  = i_char_code;
        n_ent.bg_color   = i_bg_color;
        n_ent.fg_color   = i_fg_color;
        n_ent.read_row   = i_read_row;
        n_ent.read_col   = i_read_col;
        n_ent.in_range   = (int'(i_read_row) < tch_pkg::ROWS) &&
                           (int'(i_read_col) < tch_pkg::COLUMNS);
    end

    assign n_vld = (r_vld & i_q_full) | accept;

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

    assign o_q_push  = r_vld;
    assign o_q_entry = r_ent;

endmodule

@@ src/tch_queue.sv @@
// ----------------------------------------------------------------------------
// tch_queue: decoupling queue between front end and execute unit
// A short first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
module tch_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tch_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output tch_pkg::t_entry o_data,
    output logic            o_empty
);

    tch_pkg::t_entry                r_mem [tch_pkg::QUEUE_DEPTH];
    logic [tch_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tch_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tch_pkg::QCNT_W-1:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == tch_pkg::QCNT_W'(tch_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer advance with wrap at the depth.
    function automatic logic [tch_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tch_pkg::QPTR_W-1:0] p);
        if (p == tch_pkg::QPTR_W'(tch_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/tch_back.sv @@
// ----------------------------------------------------------------------------
// tch_back: execute unit of the text console
// Holds the cursor, the screen store and its row bookkeeping, carries out
// one entry at a time and keeps the finished result in an output register.
// ----------------------------------------------------------------------------
module tch_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  tch_pkg::t_entry                 i_q_entry,
    output logic                            o_q_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic [tch_pkg::CURSOR_W-1:0]    o_cursor_location,
    output logic [tch_pkg::CELL_W-1:0]      o_cell_value
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_FILL = 5'b00100,
        S_READ = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    tch_pkg::t_entry                 r_ent;

    // Cursor and circular row bookkeeping.
    logic [tch_pkg::CIDX_W-1:0]      r_cur_col;
    logic [tch_pkg::RIDX_W-1:0]      r_cur_row;
    logic [tch_pkg::RIDX_W-1:0]      r_top;
    logic [tch_pkg::ROWS-1:0]        r_row_vld;
    logic [tch_pkg::CIDX_W-1:0]      r_fill;

    // Screen store and read path.
    logic [tch_pkg::CELL_W-1:0]      r_mem [tch_pkg::CELL_COUNT];
    logic [tch_pkg::CELL_W-1:0]      r_rd_data;
    logic                            r_rd_row_vld;

    // Output register.
    logic                            r_out_vld;
    logic [tch_pkg::CURSOR_W-1:0]    r_out_loc;
    logic [tch_pkg::CELL_W-1:0]      r_out_cell;

    logic [tch_pkg::RIDX_W-1:0]      phys_cur;
    logic [tch_pkg::RIDX_W-1:0]      phys_rd;
    logic [tch_pkg::ADDR_W-1:0]      rd_addr;
    logic                            mem_we;
    logic [tch_pkg::ADDR_W-1:0]      mem_waddr;
    logic [tch_pkg::CELL_W-1:0]      mem_wdata;
    logic [tch_pkg::CT_W-1:0]        col_t;
    logic [tch_pkg::RT_W-1:0]        row_t;
    logic                            scroll;
    logic                            need_fill;
    logic                            fill_last;
    logic                            resp_load;
    logic [tch_pkg::CELL_W-1:0]      cell_sel;

    assign phys_cur  = tch_pkg::row_map(r_cur_row, r_top);
    assign phys_rd   = tch_pkg::row_map(tch_pkg::RIDX_W'(r_ent.read_row), r_top);
    assign rd_addr   = r_ent.in_range ?
                       tch_pkg::cell_addr(phys_rd, tch_pkg::CIDX_W'(r_ent.read_col)) : '0;
    assign need_fill = (r_ent.op == tch_pkg::OP_PRINT) && !r_row_vld[phys_cur];
    assign fill_last = (r_fill == tch_pkg::CIDX_W'(tch_pkg::COLUMNS - 1));
    assign resp_load = (r_state == S_RESP) && (!r_out_vld || pop);
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;

    // Cursor movement for the current entry, with wrap and scroll detection.
    always_comb begin
        col_t = tch_pkg::CT_W'(r_cur_col);
        row_t = tch_pkg::RT_W'(r_cur_row);
        case (r_ent.op)
            tch_pkg::OP_BS: begin
                if (r_cur_col != '0) begin
                    col_t = tch_pkg::CT_W'(r_cur_col) - 1'b1;
                end
            end
            tch_pkg::OP_TAB: begin
                col_t = tch_pkg::tab_next(r_cur_col);
            end
            tch_pkg::OP_CR: begin
                col_t = '0;
            end
            tch_pkg::OP_LF: begin
                col_t = '0;
                row_t = tch_pkg::RT_W'(r_cur_row) + 1'b1;
            end
            tch_pkg::OP_PRINT: begin
                col_t = tch_pkg::CT_W'(r_cur_col) + 1'b1;
            end
            default: begin
                col_t = tch_pkg::CT_W'(r_cur_col);
            end
        endcase
        if (col_t >= tch_pkg::CT_W'(tch_pkg::COLUMNS)) begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
        scroll = (row_t >= tch_pkg::RT_W'(tch_pkg::ROWS));
    end

    // Store write port: row fill or character store.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = tch_pkg::cell_addr(phys_cur, r_cur_col);
        mem_wdata = {r_ent.bg_color, r_ent.fg_color, r_ent.char_code};
        if (r_state == S_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = tch_pkg::cell_addr(phys_cur, r_fill);
            mem_wdata = tch_pkg::BLANK_CELL;
        end else if (r_state == S_EXEC && r_ent.op == tch_pkg::OP_PRINT && !need_fill) begin
            mem_we = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = need_fill ? S_FILL : S_READ;
            end
            S_FILL: begin
                if (fill_last) begin
                    n_state = S_EXEC;
                end
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (resp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, cursor, row origin and row validity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_top     <= '0;
            r_row_vld <= '0;
            r_fill    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_fill <= '0;
                if (r_ent.op == tch_pkg::OP_CLEAR) begin
                    r_cur_col <= '0;
                    r_cur_row <= '0;
                    r_top     <= '0;
                    r_row_vld <= '0;
                end else if (!need_fill) begin
                    r_cur_col <= tch_pkg::CIDX_W'(col_t);
                    if (scroll) begin
                        // The old top row becomes the new bottom row, blank.
                        r_cur_row        <= tch_pkg::RIDX_W'(tch_pkg::ROWS - 1);
                        r_row_vld[r_top] <= 1'b0;
                        if (r_top == tch_pkg::RIDX_W'(tch_pkg::ROWS - 1)) begin
                            r_top <= '0;
                        end else begin
                            r_top <= r_top + 1'b1;
                        end
                    end else begin
                        r_cur_row <= tch_pkg::RIDX_W'(row_t);
                    end
                end
            end
            if (r_state == S_FILL) begin
                r_fill <= r_fill + 1'b1;
                if (fill_last) begin
                    r_row_vld[phys_cur] <= 1'b1;
                end
            end
        end
    end

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_entry;
        end
    end

    // Screen store with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd_data    <= r_mem[rd_addr];
            r_rd_row_vld <= r_ent.in_range & r_row_vld[phys_rd];
        end
    end

    // Cell selection: out of range reads zero, a blanked row reads blank.
    always_comb begin
        if (!r_ent.in_range) begin
            cell_sel = '0;
        end else if (!r_rd_row_vld) begin
            cell_sel = tch_pkg::BLANK_CELL;
        end else begin
            cell_sel = r_rd_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (resp_load) begin
            r_out_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_load) begin
            r_out_loc  <= tch_pkg::CURSOR_W'(int'(r_cur_row) * tch_pkg::COLUMNS +
                                             int'(r_cur_col));
            r_out_cell <= cell_sel;
        end
    end

    assign empty             = ~r_out_vld;
    assign o_cursor_location = r_out_loc;
    assign o_cell_value      = r_out_cell;

endmodule

@@ src/text_console_char_handler_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_char_handler_unit: text-mode console engine
// Keeps a screen of attribute/character cells and a cursor, interprets put,
// clear and read commands and reports the cursor location and one cell.
//
//   Channel   Direction  Handshake        Fields
//   input     in         push / full      cmd, char_code, bg_color,
//                                         fg_color, read_row, read_col
//   result    out        empty / pop      cursor_location, cell_value
//
// In the execute unit an item passes through fetch, execute, store read and result.
// A printable character stored into a row blanked by clear or scroll first
// refills all COLUMNS cells of that row with blanks, then stores the character.
// Reset needs no clearing pass: per-row validity flags and a row origin let
// clear and scroll leave the store untouched. A front stage and a two-entry queue keep
// taking items while the execute unit works or a finished result waits to be popped.
// ----------------------------------------------------------------------------
module text_console_char_handler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tch_pkg::CMD_W-1:0]         i_cmd,
    input  logic [tch_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tch_pkg::COLOR_W-1:0]       i_bg_color,
    input  logic [tch_pkg::COLOR_W-1:0]       i_fg_color,
    input  logic [tch_pkg::READ_ROW_W-1:0]    i_read_row,
    input  logic [tch_pkg::READ_COL_W-1:0]    i_read_col,
    output logic                              empty,
    input  logic                              pop,
    output logic [tch_pkg::CURSOR_W-1:0]      o_cursor_location,
    output logic [tch_pkg::CELL_W-1:0]        o_cell_value
);

    logic            f_push;
    tch_pkg::t_entry f_entry;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    tch_pkg::t_entry q_entry;

    // Front end: accept and classify.
    tch_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_bg_color   (i_bg_color),
        .i_fg_color   (i_fg_color),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_q_push     (f_push),
        .o_q_entry    (f_entry),
        .i_q_full     (q_full)
    );

    // Decoupling queue.
    tch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_entry),
        .o_empty (q_empty)
    );

    // Execute unit with the screen store and result register.
    tch_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_entry         (q_entry),
        .o_q_pop           (q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_location (o_cursor_location),
        .o_cell_value      (o_cell_value)
    );

endmodule

@@ verif/text_console_char_handler_unit_test.sv @@
// ----------------------------------------------------------------------------
// text_console_char_handler_unit_test: self-checking bench for the console
// A short table of directed items checks reset contents, field extremes and
// every control character. A long random run of text-like and noisy items
// follows. Every result is compared with a cycle-free screen and cursor
// predictor. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module text_console_char_handler_unit_test;

    // Spare command code, which the block treats as a plain read.
    localparam logic [tch_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 950;
    localparam int DRAIN_AT_ITEM  = 420;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 120;

    // One request as presented on the input ports.
    typedef struct {
        logic [tch_pkg::CMD_W-1:0]      cmd;
        logic [tch_pkg::CHAR_W-1:0]     code;
        logic [tch_pkg::COLOR_W-1:0]    back;
        logic [tch_pkg::COLOR_W-1:0]    fore;
        logic [tch_pkg::READ_ROW_W-1:0] rrow;
        logic [tch_pkg::READ_COL_W-1:0] rcol;
    } t_console_req;

    // One report as seen on the result ports.
    typedef struct {
        logic [tch_pkg::CURSOR_W-1:0] cursor;
        logic [tch_pkg::CELL_W-1:0]   cell_word;
    } t_console_report;

    // A directed row; the report is typed in only where typed is set.
    typedef struct {
        logic [tch_pkg::CMD_W-1:0]      cmd;
        logic [tch_pkg::CHAR_W-1:0]     code;
        logic [tch_pkg::COLOR_W-1:0]    back;
        logic [tch_pkg::COLOR_W-1:0]    fore;
        logic [tch_pkg::READ_ROW_W-1:0] rrow;
        logic [tch_pkg::READ_COL_W-1:0] rcol;
        bit                             typed;
        logic [tch_pkg::CURSOR_W-1:0]   cursor;
        logic [tch_pkg::CELL_W-1:0]     cell_word;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 22;

    t_directed_row directed_tbl [DIRECTED_ROWS] = '{
        // Reset contents and read extremes, in and out of range.
        '{tch_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0,  7'd0,   1'b1, 11'd0,  16'h0F20},
        '{tch_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127, 1'b1, 11'd0,  16'h0000},
        '{tch_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd79,  1'b1, 11'd0,  16'h0F20},
        '{tch_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0,   1'b1, 11'd0,  16'h0000},
        '{tch_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0,  7'd80,  1'b1, 11'd0,  16'h0000},
        // Printable extremes and colour extremes.
        '{tch_pkg::CMD_PUT, 8'h41, 4'hF, 4'hF, 5'd0, 7'd0, 1'b1, 11'd1, 16'hFF41},
        '{tch_pkg::CMD_PUT, 8'h7F, 4'h0, 4'h0, 5'd0, 7'd1, 1'b1, 11'd2, 16'h007F},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_SPACE, 4'hA, 4'h5, 5'd0, 7'd2, 1'b1, 11'd3, 16'hA520},
        // High bytes are ignored.
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_HIGH, 4'hF, 4'hF, 5'd0, 7'd3, 1'b1, 11'd3, 16'h0F20},
        '{tch_pkg::CMD_PUT, 8'hFF, 4'h3, 4'hC, 5'd0, 7'd3, 1'b1, 11'd3, 16'h0F20},
        // Cursor movement characters.
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_BS,  4'h0, 4'h0, 5'd0, 7'd2, 1'b1, 11'd2, 16'hA520},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_TAB, 4'h0, 4'h0, 5'd0, 7'd0, 1'b1, 11'd8, 16'hFF41},
        '{tch_pkg::CMD_PUT, 8'h00, 4'h1, 4'h2, 5'd0, 7'd8, 1'b1, 11'd8, 16'h0F20},
        '{tch_pkg::CMD_PUT, 8'h1F, 4'h1, 4'h2, 5'd0, 7'd8, 1'b1, 11'd8, 16'h0F20},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_CR,  4'h0, 4'h0, 5'd0, 7'd0, 1'b1, 11'd0, 16'hFF41},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_BS,  4'h0, 4'h0, 5'd0, 7'd0, 1'b1, 11'd0, 16'hFF41},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_LF,  4'h0, 4'h0, 5'd1, 7'd0, 1'b1, 11'd80, 16'h0F20},
        // The spare command and a read with put-like fields change nothing.
        '{CMD_SPARE, 8'h55, 4'h6, 4'h9, 5'd0, 7'd0, 1'b1, 11'd80, 16'hFF41},
        '{tch_pkg::CMD_READ, 8'h41, 4'h7, 4'h7, 5'd0, 7'd1, 1'b0, 11'd0, 16'h0000},
        // Clear, then a store into the freshly cleared screen.
        '{tch_pkg::CMD_CLEAR, 8'h41, 4'hF, 4'hF, 5'd0, 7'd0, 1'b1, 11'd0, 16'h0F20},
        '{tch_pkg::CMD_PUT, 8'h7E, 4'h5, 4'hA, 5'd0, 7'd0, 1'b1, 11'd1, 16'h5A7E},
        '{tch_pkg::CMD_PUT, tch_pkg::CHAR_TAB, 4'h0, 4'h0, 5'd0, 7'd1, 1'b0, 11'd0, 16'h0000}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [tch_pkg::CMD_W-1:0]       i_cmd = tch_pkg::CMD_READ;
    logic [tch_pkg::CHAR_W-1:0]      i_char_code = '0;
    logic [tch_pkg::COLOR_W-1:0]     i_bg_color = '0;
    logic [tch_pkg::COLOR_W-1:0]     i_fg_color = '0;
    logic [tch_pkg::READ_ROW_W-1:0]  i_read_row = '0;
    logic [tch_pkg::READ_COL_W-1:0]  i_read_col = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [tch_pkg::CURSOR_W-1:0]    o_cursor_location;
    logic [tch_pkg::CELL_W-1:0]      o_cell_value;

    // Predicted screen and cursor.
    logic [tch_pkg::CELL_W-1:0] screen_model [tch_pkg::CELL_COUNT];
    int unsigned                cursor_col;
    int unsigned                cursor_row;

    // Reports still owed by the block, oldest first.
    t_console_report   pending_reports [$];

    int unsigned items_sent      = 0;
    int unsigned reports_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned scroll_count    = 0;
    int unsigned wrap_count      = 0;
    int unsigned clear_count     = 0;
    int unsigned idle_cycles     = 0;
    int unsigned burst_left      = 0;
    int unsigned stall_phase     = 0;
    logic [15:0] stall_mask = 16'hFFFF;

    text_console_char_handler_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_cmd             (i_cmd),
        .i_char_code       (i_char_code),
        .i_bg_color        (i_bg_color),
        .i_fg_color        (i_fg_color),
        .i_read_row        (i_read_row),
        .i_read_col        (i_read_col),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_location (o_cursor_location),
        .o_cell_value      (o_cell_value)
    );

    always #5 i_clk = ~i_clk;

    // Blank the whole predicted screen and home the cursor.
    function automatic void screen_clear();
        for (int i = 0; i < tch_pkg::CELL_COUNT; i++) begin
            screen_model[i] = tch_pkg::BLANK_CELL;
        end
        cursor_col = 0;
        cursor_row = 0;
    endfunction

    // Apply one request to the predicted screen and return its report.
    function automatic t_console_report console_apply(input t_console_req req);
        t_console_report rep;
        if (req.cmd == tch_pkg::CMD_PUT && req.code < tch_pkg::CHAR_HIGH) begin
            if (req.code == tch_pkg::CHAR_BS) begin
                if (cursor_col != 0) begin
                    cursor_col--;
                end
            end else if (req.code == tch_pkg::CHAR_TAB) begin
                cursor_col = cursor_col + tch_pkg::TAB_WIDTH -
                             (cursor_col % tch_pkg::TAB_WIDTH);
            end else if (req.code == tch_pkg::CHAR_CR) begin
                cursor_col = 0;
            end else if (req.code == tch_pkg::CHAR_LF) begin
                cursor_col = 0;
                cursor_row++;
            end else if (req.code >= tch_pkg::CHAR_SPACE) begin
                screen_model[cursor_row * tch_pkg::COLUMNS + cursor_col] =
                    {req.back, req.fore, req.code};
                cursor_col++;
            end
            // Wrap past the last column.
            if (cursor_col >= tch_pkg::COLUMNS) begin
                cursor_col = 0;
                cursor_row++;
                wrap_count++;
            end
            // Scroll up past the last row and blank the new bottom row.
            if (cursor_row >= tch_pkg::ROWS) begin
                for (int i = 0; i < tch_pkg::CELL_COUNT - tch_pkg::COLUMNS; i++) begin
                    screen_model[i] = screen_model[i + tch_pkg::COLUMNS];
                end
                for (int i = tch_pkg::CELL_COUNT - tch_pkg::COLUMNS;
                     i < tch_pkg::CELL_COUNT; i++) begin
                    screen_model[i] = tch_pkg::BLANK_CELL;
                end
                cursor_row = tch_pkg::ROWS - 1;
                scroll_count++;
            end
        end else if (req.cmd == tch_pkg::CMD_CLEAR) begin
            screen_clear();
            clear_count++;
        end
        rep.cursor = tch_pkg::CURSOR_W'(cursor_row * tch_pkg::COLUMNS + cursor_col);
        if (req.rrow < tch_pkg::ROWS && req.rcol < tch_pkg::COLUMNS) begin
            rep.cell_word = screen_model[int'(req.rrow) * tch_pkg::COLUMNS + int'(req.rcol)];
        end else begin
            rep.cell_word = '0;
        end
        return rep;
    endfunction

    // Draw a random character: text-like in text mode, any byte otherwise.
    function automatic logic [tch_pkg::CHAR_W-1:0] random_char(input bit text_mode);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!text_mode) begin
            return tch_pkg::CHAR_W'($urandom_range(0, 255));
        end
        if (pick < 62) begin
            return tch_pkg::CHAR_W'($urandom_range(32, 127));
        end else if (pick < 74) begin
            return tch_pkg::CHAR_LF;
        end else if (pick < 82) begin
            return tch_pkg::CHAR_TAB;
        end else if (pick < 88) begin
            return tch_pkg::CHAR_BS;
        end else if (pick < 91) begin
            return tch_pkg::CHAR_CR;
        end else if (pick < 96) begin
            return tch_pkg::CHAR_W'($urandom_range(128, 255));
        end
        return tch_pkg::CHAR_W'($urandom_range(0, 31));
    endfunction

    // Build one random request; half of the reads look near the cursor.
    function automatic t_console_req random_request(input bit text_mode);
        t_console_req req;
        int unsigned  pick;
        pick = $urandom_range(0, 999);
        if (text_mode) begin
            req.cmd = (pick < 6) ? tch_pkg::CMD_CLEAR : (pick < 60) ? tch_pkg::CMD_READ :
                      (pick < 75) ? CMD_SPARE : tch_pkg::CMD_PUT;
        end else begin
            req.cmd = (pick < 15) ? tch_pkg::CMD_CLEAR :
                      tch_pkg::CMD_W'($urandom_range(0, 3));
            if (req.cmd == tch_pkg::CMD_CLEAR && pick >= 15) begin
                req.cmd = tch_pkg::CMD_PUT;
            end
        end
        req.code = random_char(text_mode);
        req.back = tch_pkg::COLOR_W'($urandom_range(0, 15));
        req.fore = tch_pkg::COLOR_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            req.rrow = tch_pkg::READ_ROW_W'(cursor_row);
            req.rcol = tch_pkg::READ_COL_W'((cursor_col > 2) ?
                       $urandom_range(cursor_col - 2, cursor_col) : cursor_col);
        end else if (pick < 70) begin
            req.rrow = ($urandom_range(0, 1) != 0) ?
                       tch_pkg::READ_ROW_W'(tch_pkg::ROWS - 1) : '0;
            req.rcol = tch_pkg::READ_COL_W'($urandom_range(0, tch_pkg::COLUMNS - 1));
        end else if (pick < 94) begin
            req.rrow = tch_pkg::READ_ROW_W'($urandom_range(0, tch_pkg::ROWS - 1));
            req.rcol = tch_pkg::READ_COL_W'($urandom_range(0, tch_pkg::COLUMNS - 1));
        end else begin
            req.rrow = tch_pkg::READ_ROW_W'($urandom_range(0, 31));
            req.rcol = tch_pkg::READ_COL_W'($urandom_range(0, 127));
        end
        return req;
    endfunction

    // Present one item, wait until it is taken and queue its report.
    task automatic send_request(input t_console_req req, input bit typed,
                                input t_console_report typed_rep);
        t_console_report predicted;
        push         <= 1'b1;
        i_cmd        <= req.cmd;
        i_char_code  <= req.code;
        i_bg_color   <= req.back;
        i_fg_color   <= req.fore;
        i_read_row   <= req.rrow;
        i_read_col   <= req.rcol;
        do begin
            @(posedge i_clk);
        end while (full);
        predicted = console_apply(req);
        pending_reports.push_back(typed ? typed_rep : predicted);
        items_sent++;
    endtask

    // Sender pacing: bursts of random length, usually followed by a gap.
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Receiver: pops on a rotating mask that is redrawn periodically at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_phase % 64 == 63) begin
                case ($urandom_range(0, 3))
                    0: stall_mask <= 16'hFFFF;
                    1: stall_mask <= 16'h0101;
                    default: stall_mask <= 16'($urandom_range(0, 65535)) | 16'h0001;
                endcase
            end
            pop <= stall_mask[stall_phase % 16];
            stall_phase <= stall_phase + 1;
        end
    end

    // Compare each popped report with the oldest expectation.
    always @(posedge i_clk) begin
        t_console_report want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected report: cursor_location %0d, cell_value %h",
                       o_cursor_location, o_cell_value);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (o_cursor_location !== want.cursor) begin
                    $error("cursor_location mismatch: expected %0d, actual %0d",
                           want.cursor, o_cursor_location);
                    mismatches++;
                end
                if (o_cell_value !== want.cell_word) begin
                    $error("cell_value mismatch: expected %h, actual %h",
                           want.cell_word, o_cell_value);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Main sequence: reset, directed table, random run, drain and verdict.
    initial begin
        t_console_req    req;
        t_console_report rep;
        bit              text_mode;
        int unsigned     mode_left;
        screen_clear();
        text_mode       = 1'b1;
        mode_left       = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (directed_tbl[i]) begin
            req.cmd       = directed_tbl[i].cmd;
            req.code      = directed_tbl[i].code;
            req.back      = directed_tbl[i].back;
            req.fore      = directed_tbl[i].fore;
            req.rrow      = directed_tbl[i].rrow;
            req.rcol      = directed_tbl[i].rcol;
            rep.cursor    = directed_tbl[i].cursor;
            rep.cell_word = directed_tbl[i].cell_word;
            send_request(req, directed_tbl[i].typed, rep);
            pace_sender();
        end

        // Random run: long text-like stretches with short noisy ones between.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                text_mode = ($urandom_range(0, 4) != 0);
                mode_left = text_mode ? $urandom_range(40, 200) : $urandom_range(5, 30);
            end
            mode_left--;
            req = random_request(text_mode);
            send_request(req, 1'b0, rep);
            if (n == DRAIN_AT_ITEM) begin
                // Hold off until every owed report has come back.
                push <= 1'b0;
                while (pending_reports.size() != 0) @(posedge i_clk);
            end else begin
                pace_sender();
            end
        end

        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items and checked %0d reports.", items_sent, reports_checked);
        $display("Screen saw %0d scrolls, %0d line wraps and %0d clears.",
                 scroll_count, wrap_count, clear_count);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
